[hw/rtl/complete_linkage_clusterer_assert.svh]
// assertion macros for the complete linkage clusterer checker
`ifndef COMPLETE_LINKAGE_CLUSTERER_ASSERT_SVH
`define COMPLETE_LINKAGE_CLUSTERER_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define CLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clc check failed");

// next-cycle implication, ignored while reset is high
`define CLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clc check failed");

// next-cycle implication that also holds across reset
`define CLC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("clc reset check failed");

`endif

[hw/rtl/clc_pkg.sv]
// shared types and constants for the complete linkage clusterer
package clc_pkg;
  localparam int DIST_W      = 24;
  localparam int KIND_W      = 2;
  localparam int IDX_PORT_W  = 6;
  localparam int CNT_PORT_W  = 7;
  localparam int OUT_W       = 16;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPOT  = 2'd0,
    KIND_DIST  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOT_COUNT = 1'b1;
endpackage

[hw/rtl/clc_ram.sv]
// simple memory: one write port, two registered read ports
module clc_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);
  logic [W-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

[hw/rtl/clc_div.sv]
// restoring divider, one quotient bit per cycle
module clc_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quot[NUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(NUM_W - 1));
      if (start) begin
        busy    <= 1'b1;
        rem     <= '0;
        quot    <= num;
        divisor <= den;
        cnt     <= '0;
      end else if (busy) begin
        rem  <= ge ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
        quot <= {quot[NUM_W-2:0], ge};
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/complete_linkage_clusterer.sv]
// complete linkage clusterer: load stores, merge sequencer and result walk
// Usage: configuration is written through cfg_we/cfg_index/cfg_data while idle
// (index 0 max_link_distance, index 1 spot_count). Items arrive on the
// in_valid/in_ready channel: kind 0 loads a spot position, kind 1 loads one
// lower-triangle distance, kind 2 starts a clustering run. Load items can
// be taken back to back. A start item makes the block busy (in_ready low) until its
// last result has been transferred on out_valid/out_ready.
// A run starts with slot set-up, then each merge round of m clusters runs a
// closest-pair search over the distance memory (one read per cycle), a row
// walk with its writes, and list splicing. Each final cluster then takes a
// slot read, a list walk, a farthest-pair search and midpoint through one
// squaring pipeline (the search is skipped for a single member), two divider
// passes, and the emission of its results. The search uses one read port of
// the distance memory, and one squaring pipeline is shared by all pairs.
// Reset clears the sequencer, max_link and output valid and sets spot_count
// to 1; stores are undefined until loaded. A stalled receiver simply holds
// the block in its emit state with the result registered and unchanged.
module complete_linkage_clusterer #(
  parameter int MAX_SPOTS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [clc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clc_pkg::DIST_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [clc_pkg::KIND_W-1:0]         kind,
  input  logic [clc_pkg::IDX_PORT_W-1:0]     row_index,
  input  logic [clc_pkg::IDX_PORT_W-1:0]     col_index,
  input  logic [clc_pkg::OUT_W-1:0]          pos_x,
  input  logic [clc_pkg::OUT_W-1:0]          pos_z,
  input  logic [clc_pkg::DIST_W-1:0]         distance,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [clc_pkg::IDX_PORT_W-1:0]     cluster_id,
  output logic [clc_pkg::IDX_PORT_W-1:0]     spot_index,
  output logic [clc_pkg::OUT_W-1:0]          mean_x,
  output logic [clc_pkg::OUT_W-1:0]          mean_z,
  output logic [clc_pkg::OUT_W-1:0]          mid_x,
  output logic [clc_pkg::OUT_W-1:0]          mid_z,
  output logic                               cluster_end,
  output logic                               last
);
  import clc_pkg::*;

  localparam int IW   = $clog2(MAX_SPOTS);
  localparam int CNW  = $clog2(MAX_SPOTS + 1);
  localparam int AW   = 2 * IW;
  localparam int CW   = COORD_BITS;
  localparam int SUMW = CW + CNW;
  localparam int SQW  = 2 * CW + 1;
  localparam int SLW  = 2 * IW + CNW;
  localparam int BW   = IW + 2 * CW;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_SRCH, S_SRCH_END, S_DECIDE, S_UPD, S_UPD_WR,
    S_MEM1, S_MEM2, S_MEM3, S_CL, S_CL2, S_WALK, S_WALK2, S_PAIR,
    S_PDRAIN, S_MID, S_MID2, S_DIVX, S_DIVZ, S_EMIT_RD, S_EMIT_LD, S_EMIT_W
  } state_t;

  typedef enum logic [2:0] {
    PH_ROW_JS, PH_COL_MID, PH_COL_HI, PH_MOVE_ROW, PH_MOVE_COL
  } phase_t;

  state_t state;
  phase_t ph;

  logic [DIST_W-1:0]     max_link;
  logic [CNT_PORT_W-1:0] spot_cnt;

  logic [CNW-1:0]    m;
  logic [IW-1:0]     ri, rj, si, sj, j, mm1;
  logic [DIST_W-1:0] best;
  logic              sv, sfirst;
  logic [IW-1:0]     pi, pj;
  logic [CNW-1:0]    k;
  logic [IW-1:0]     c, p;
  logic [CNW-1:0]    csz;
  logic [SUMW-1:0]   sumx, sumz;
  logic [IW-1:0]     fa, fb, ir, jr;
  logic              finit;
  logic [1:0]        drain;
  logic              v1, v2, v3, i1, i2, i3;
  logic [IW-1:0]     a1, b1, a2, b2, a3, b3;
  logic [CW-1:0]     dx, dz;
  logic [2*CW-1:0]   sqx, sqz;
  logic [SQW-1:0]    bestd, dsum;
  logic [OUT_W-1:0]  mid_x_r, mid_z_r, mean_x_r, mean_z_r;

  // distance memory
  logic              d_we;
  logic [AW-1:0]     d_wa, d_ra, d_rb;
  logic [DIST_W-1:0] d_wd, d_qa, d_qb;
  logic [AW-1:0]     upd_wa, upd_ra, upd_rb;
  logic              upd_ok, upd_last;

  // slot table {head, tail, size}
  logic           s_we;
  logic [IW-1:0]  s_wa, s_ra, s_rb;
  logic [SLW-1:0] s_wd, s_qa, s_qb;
  logic [IW-1:0]  sa_head, sa_tail, sb_head, sb_tail;
  logic [CNW-1:0] sa_size, sb_size;

  // member links, spot positions, per-cluster member buffer
  logic           n_we;
  logic [IW-1:0]  n_q;
  logic           p_we;
  logic [2*CW-1:0] p_q;
  logic           b_we;
  logic [IW-1:0]  b_ra, b_rb;
  logic [BW-1:0]  b_qa, b_qb;
  logic [CW-1:0]  xa, za, xb, zb;

  logic             div_start, div_done;
  logic [SUMW-1:0]  div_q;

  logic           in_row_ok, in_col_ok;
  logic [CNW-1:0] n_start;
  logic           emit_end;

  assign in_ready = (state == S_IDLE);
  assign mm1      = IW'(m - 1'b1);

  assign in_row_ok = {1'b0, row_index} < (IDX_PORT_W + 1)'(MAX_SPOTS);
  assign in_col_ok = col_index < row_index;

  always_comb begin
    if (spot_cnt == '0) begin
      n_start = CNW'(1);
    end else if (spot_cnt > CNT_PORT_W'(MAX_SPOTS)) begin
      n_start = CNW'(MAX_SPOTS);
    end else begin
      n_start = CNW'(spot_cnt);
    end
  end

  // addresses of the merge update phases
  always_comb begin
    upd_wa = '0;
    upd_ra = '0;
    upd_rb = '0;
    upd_ok = 1'b0;
    case (ph)
      PH_ROW_JS: begin
        upd_wa = {rj, j};
        upd_ra = {ri, j};
        upd_rb = {rj, j};
        upd_ok = j < rj;
      end
      PH_COL_MID: begin
        upd_wa = {j, rj};
        upd_ra = {ri, j};
        upd_rb = {j, rj};
        upd_ok = (j > rj) && (j < ri);
      end
      PH_COL_HI: begin
        upd_wa = {j, rj};
        upd_ra = {j, ri};
        upd_rb = {j, rj};
        upd_ok = j > ri;
      end
      PH_MOVE_ROW: begin
        upd_wa = {ri, j};
        upd_ra = {mm1, j};
        upd_rb = {mm1, j};
        upd_ok = j < ri;
      end
      PH_MOVE_COL: begin
        upd_wa = {j, ri};
        upd_ra = {mm1, j};
        upd_rb = {mm1, j};
        upd_ok = (j > ri) && (j < mm1);
      end
      default: begin
        upd_ok = 1'b0;
      end
    endcase
  end

  assign upd_last = (j == mm1);

  assign d_ra = (state == S_SRCH) ? {si, sj} : upd_ra;
  assign d_rb = upd_rb;

  always_comb begin
    d_we = 1'b0;
    d_wa = upd_wa;
    d_wd = (ph == PH_MOVE_ROW || ph == PH_MOVE_COL) ? d_qa :
           ((d_qa > d_qb) ? d_qa : d_qb);
    if (state == S_IDLE) begin
      d_we = in_valid && (kind == KIND_DIST) && in_row_ok && in_col_ok;
      d_wa = {IW'(row_index), IW'(col_index)};
      d_wd = distance;
    end else if (state == S_UPD_WR) begin
      d_we = 1'b1;
    end
  end

  clc_ram #(.W(DIST_W), .AW(AW)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .raddr_a(d_ra), .raddr_b(d_rb), .rdata_a(d_qa), .rdata_b(d_qb)
  );

  assign sa_head = s_qa[SLW-1 -: IW];
  assign sa_tail = s_qa[SLW-1-IW -: IW];
  assign sa_size = s_qa[CNW-1:0];
  assign sb_head = s_qb[SLW-1 -: IW];
  assign sb_tail = s_qb[SLW-1-IW -: IW];
  assign sb_size = s_qb[CNW-1:0];

  always_comb begin
    s_ra = c;
    s_rb = rj;
    s_we = 1'b0;
    s_wa = IW'(k);
    s_wd = {IW'(k), IW'(k), CNW'(1)};
    case (state)
      S_INIT: begin
        s_we = 1'b1;
      end
      S_MEM1: begin
        s_ra = ri;
      end
      S_MEM2: begin
        s_ra = mm1;
        s_we = 1'b1;
        s_wa = rj;
        s_wd = {sb_head, sa_tail, CNW'(sb_size + sa_size)};
      end
      S_MEM3: begin
        s_we = 1'b1;
        s_wa = ri;
        s_wd = s_qa;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  clc_ram #(.W(SLW), .AW(IW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
    .raddr_a(s_ra), .raddr_b(s_rb), .rdata_a(s_qa), .rdata_b(s_qb)
  );

  // splice: the old tail of cluster js now points at the head of cluster is
  assign n_we = (state == S_MEM2);

  clc_ram #(.W(IW), .AW(IW)) u_next (
    .clk(clk), .we(n_we), .waddr(sb_tail), .wdata(sa_head),
    .raddr_a(p), .raddr_b(p), .rdata_a(n_q), .rdata_b()
  );

  assign p_we = (state == S_IDLE) && in_valid && (kind == KIND_SPOT) && in_row_ok;

  clc_ram #(.W(2*CW), .AW(IW)) u_spot (
    .clk(clk), .we(p_we), .waddr(IW'(row_index)), .wdata({CW'(pos_x), CW'(pos_z)}),
    .raddr_a(p), .raddr_b(p), .rdata_a(p_q), .rdata_b()
  );

  assign b_we = (state == S_WALK2);

  always_comb begin
    case (state)
      S_PAIR: begin
        b_ra = fa;
        b_rb = fb;
      end
      S_MID: begin
        b_ra = ir;
        b_rb = jr;
      end
      default: begin
        b_ra = IW'(k);
        b_rb = jr;
      end
    endcase
  end

  clc_ram #(.W(BW), .AW(IW)) u_mbuf (
    .clk(clk), .we(b_we), .waddr(IW'(k)), .wdata({p, p_q}),
    .raddr_a(b_ra), .raddr_b(b_rb), .rdata_a(b_qa), .rdata_b(b_qb)
  );

  assign xa = b_qa[2*CW-1:CW];
  assign za = b_qa[CW-1:0];
  assign xb = b_qb[2*CW-1:CW];
  assign zb = b_qb[CW-1:0];

  assign div_start = (state == S_MID2) || ((state == S_DIVX) && div_done);

  clc_div #(.NUM_W(SUMW), .DEN_W(CNW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num((state == S_MID2) ? sumx : sumz), .den(csz),
    .done(div_done), .quot(div_q)
  );

  assign dsum     = {1'b0, sqx} + {1'b0, sqz};
  assign emit_end = ((k + 1'b1) == csz);

  // closest-pair compare and farthest-pair squaring pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      sv     <= (state == S_SRCH);
      sfirst <= (si == IW'(1)) && (sj == '0);
      pi     <= si;
      pj     <= sj;
      if (sv && (sfirst || d_qa < best)) begin
        best <= d_qa;
        ri   <= pi;
        rj   <= pj;
      end

      v1 <= (state == S_PAIR);
      i1 <= finit;
      a1 <= fa;
      b1 <= fb;
      v2 <= v1;
      i2 <= i1;
      a2 <= a1;
      b2 <= b1;
      dx <= (xa > xb) ? xa - xb : xb - xa;
      dz <= (za > zb) ? za - zb : zb - za;
      v3 <= v2;
      i3 <= i2;
      a3 <= a2;
      b3 <= b2;
      sqx <= dx * dx;
      sqz <= dz * dz;
      if (v3 && (i3 || dsum > bestd)) begin
        bestd <= dsum;
        ir    <= a3;
        jr    <= b3;
      end else if (state == S_WALK2 && emit_end) begin
        ir <= '0;
        jr <= '0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_link  <= '0;
      spot_cnt  <= CNT_PORT_W'(1);
      out_valid <= 1'b0;
      ph        <= PH_ROW_JS;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_LINK:   max_link <= cfg_data;
          CFG_SPOT_COUNT: spot_cnt <= CNT_PORT_W'(cfg_data);
          default:        max_link <= max_link;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && kind == KIND_START) begin
            m     <= n_start;
            k     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if ((k + 1'b1) == m) begin
            k  <= '0;
            c  <= '0;
            si <= IW'(1);
            sj <= '0;
            state <= (m == CNW'(1)) ? S_CL : S_SRCH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SRCH: begin
          if (sj == IW'(si - 1'b1)) begin
            if (si == mm1) begin
              state <= S_SRCH_END;
            end else begin
              si <= si + 1'b1;
              sj <= '0;
            end
          end else begin
            sj <= sj + 1'b1;
          end
        end
        S_SRCH_END: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (best > max_link) begin
            c     <= '0;
            state <= S_CL;
          end else begin
            ph    <= PH_ROW_JS;
            j     <= '0;
            state <= S_UPD;
          end
        end
        S_UPD, S_UPD_WR: begin
          if (state == S_UPD && upd_ok) begin
            state <= S_UPD_WR;
          end else if (upd_last) begin
            j <= '0;
            if (ph == PH_MOVE_COL) begin
              state <= S_MEM1;
            end else begin
              ph    <= phase_t'(ph + 1'b1);
              state <= S_UPD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_UPD;
          end
        end
        S_MEM1: begin
          state <= S_MEM2;
        end
        S_MEM2: begin
          state <= S_MEM3;
        end
        S_MEM3: begin
          m  <= m - 1'b1;
          si <= IW'(1);
          sj <= '0;
          c  <= '0;
          state <= (m == CNW'(2)) ? S_CL : S_SRCH;
        end
        S_CL: begin
          state <= S_CL2;
        end
        S_CL2: begin
          p     <= sa_head;
          csz   <= sa_size;
          k     <= '0;
          sumx  <= '0;
          sumz  <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          state <= S_WALK2;
        end
        S_WALK2: begin
          sumx <= sumx + SUMW'(p_q[2*CW-1:CW]);
          sumz <= sumz + SUMW'(p_q[CW-1:0]);
          p    <= n_q;
          if (emit_end) begin
            k <= '0;
            if (csz == CNW'(1)) begin
              state <= S_MID;
            end else begin
              fa    <= IW'(1);
              fb    <= '0;
              finit <= 1'b1;
              state <= S_PAIR;
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_WALK;
          end
        end
        S_PAIR: begin
          if (finit) begin
            finit <= 1'b0;
            fa    <= '0;
            fb    <= '0;
          end else if (CNW'(fb) == csz - 1'b1) begin
            fb <= '0;
            if (CNW'(fa) == csz - 1'b1) begin
              drain <= '0;
              state <= S_PDRAIN;
            end else begin
              fa <= fa + 1'b1;
            end
          end else begin
            fb <= fb + 1'b1;
          end
        end
        S_PDRAIN: begin
          if (drain == 2'd2) begin
            state <= S_MID;
          end else begin
            drain <= drain + 1'b1;
          end
        end
        S_MID: begin
          state <= S_MID2;
        end
        S_MID2: begin
          mid_x_r <= OUT_W'(({1'b0, xa} + {1'b0, xb}) >> 1);
          mid_z_r <= OUT_W'(({1'b0, za} + {1'b0, zb}) >> 1);
          state   <= S_DIVX;
        end
        S_DIVX: begin
          if (div_done) begin
            mean_x_r <= OUT_W'(div_q);
            state    <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          if (div_done) begin
            mean_z_r <= OUT_W'(div_q);
            k        <= '0;
            state    <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid   <= 1'b1;
          cluster_id  <= IDX_PORT_W'(c);
          spot_index  <= IDX_PORT_W'(b_qa[BW-1 -: IW]);
          cluster_end <= emit_end;
          last        <= emit_end && ((CNW'(c) + 1'b1) == m);
          mean_x      <= emit_end ? mean_x_r : '0;
          mean_z      <= emit_end ? mean_z_r : '0;
          mid_x       <= emit_end ? mid_x_r : '0;
          mid_z       <= emit_end ? mid_z_r : '0;
          state       <= S_EMIT_W;
        end
        S_EMIT_W: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cluster_end) begin
              if (last) begin
                state <= S_IDLE;
              end else begin
                c     <= c + 1'b1;
                state <= S_CL;
              end
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

[hw/rtl/clc_checker.sv]
// port-level checks for the complete linkage clusterer, bound to the top level
`include "complete_linkage_clusterer_assert.svh"
module clc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [clc_pkg::IDX_PORT_W-1:0] cluster_id,
  input logic [clc_pkg::IDX_PORT_W-1:0] spot_index,
  input logic                           cluster_end,
  input logic                           last
);
  // results only come out while the block is busy with a run
  `CLC_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  // the final result of a run always closes a cluster
  `CLC_ASSERT_IMP(a_last_ends, out_valid && last, cluster_end)
  // a stalled result holds
  `CLC_ASSERT_NXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(spot_index) && $stable(cluster_id))
  // reset drops the output channel
  `CLC_ASSERT_RST(a_rst, rst, !out_valid)
endmodule

bind complete_linkage_clusterer clc_checker u_clc_checker (.*);

[bench/tb_complete_linkage_clusterer.sv]
// self-checking testbench for the complete linkage clusterer
`timescale 1ns / 1ps

module tb_complete_linkage_clusterer;
  import clc_pkg::*;

  localparam int NSPOT = 64;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_FULL = 24'hFFFFFF;

  typedef struct packed {
    logic [5:0]  cid;
    logic [5:0]  spot;
    logic [15:0] mx;
    logic [15:0] mz;
    logic [15:0] px;
    logic [15:0] pz;
    logic        cend;
    logic        fin;
  } member_rec_t;

  typedef struct {
    bit                 is_cfg;
    logic [0:0]         ci;
    logic [DIST_W-1:0]  cv;
    logic [KIND_W-1:0]  k;
    logic [5:0]         r;
    logic [5:0]         c;
    logic [15:0]        x;
    logic [15:0]        z;
    logic [DIST_W-1:0]  d;
    bit                 typed;
    member_rec_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [5:0] row_index = '0, col_index = '0;
  logic [15:0] pos_x = '0, pos_z = '0;
  logic [DIST_W-1:0] distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] cluster_id, spot_index;
  logic [15:0] mean_x, mean_z, mid_x, mid_z;
  logic cluster_end, last_o;

  complete_linkage_clusterer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .row_index(row_index),
    .col_index(col_index), .pos_x(pos_x), .pos_z(pos_z), .distance(distance),
    .out_valid(out_valid), .out_ready(out_ready), .cluster_id(cluster_id),
    .spot_index(spot_index), .mean_x(mean_x), .mean_z(mean_z), .mid_x(mid_x),
    .mid_z(mid_z), .cluster_end(cluster_end), .last(last_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's state
  logic [DIST_W-1:0] link_dist [NSPOT][NSPOT];
  logic [15:0]       spot_x [NSPOT];
  logic [15:0]       spot_z [NSPOT];
  logic [5:0]        members [NSPOT][NSPOT];
  int unsigned       group_size [NSPOT];
  int unsigned       live_groups;
  logic [DIST_W-1:0] merge_limit;
  logic [6:0]        count_reg;

  member_rec_t pending_members [$];
  member_rec_t fresh [$];
  int errors = 0;
  int accepted_items = 0;
  int members_seen = 0;
  int starts = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint unsigned span_sq(int a, int b);
    longint unsigned dx, dz;
    dx = spot_x[a] > spot_x[b] ? spot_x[a] - spot_x[b] : spot_x[b] - spot_x[a];
    dz = spot_z[a] > spot_z[b] ? spot_z[a] - spot_z[b] : spot_z[b] - spot_z[a];
    return dx * dx + dz * dz;
  endfunction

  function automatic logic [DIST_W-1:0] dmax(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    return a > b ? a : b;
  endfunction

  // agglomerate with complete linkage, then list every member
  task automatic cluster_and_list(int n);
    int is, js, ir, jr, tot;
    logic [DIST_W-1:0] best;
    longint unsigned sx, sz, bd, dd;
    member_rec_t rec;
    for (int i = 0; i < n; i++) begin
      members[i][0] = i[5:0];
      group_size[i] = 1;
    end
    live_groups = n;
    for (int m = n; m > 1; m--) begin
      is = 1; js = 0; best = link_dist[1][0];
      for (int i = 1; i < m; i++)
        for (int j = 0; j < i; j++)
          if (link_dist[i][j] < best) begin
            best = link_dist[i][j]; is = i; js = j;
          end
      if (best > merge_limit) break;
      for (int j = 0; j < js; j++) link_dist[js][j] = dmax(link_dist[is][j], link_dist[js][j]);
      for (int j = js + 1; j < is; j++)
        link_dist[j][js] = dmax(link_dist[is][j], link_dist[j][js]);
      for (int j = is + 1; j < m; j++)
        link_dist[j][js] = dmax(link_dist[j][is], link_dist[j][js]);
      for (int j = 0; j < is; j++) link_dist[is][j] = link_dist[m-1][j];
      for (int j = is + 1; j + 1 < m; j++) link_dist[j][is] = link_dist[m-1][j];
      for (int j = 0; j < group_size[is] && group_size[js] < NSPOT; j++) begin
        members[js][group_size[js]] = members[is][j];
        group_size[js]++;
      end
      members[is] = members[m-1];
      group_size[is] = group_size[m-1];
      live_groups = m - 1;
    end
    tot = 0;
    for (int c = 0; c < live_groups; c++) begin
      for (int k = 0; k < group_size[c]; k++) begin
        rec = '0;
        rec.cid = c[5:0];
        rec.spot = members[c][k];
        if (k + 1 == group_size[c]) begin
          rec.cend = 1'b1;
          sx = 0; sz = 0; ir = 0; jr = 0;
          for (int a = 0; a < group_size[c]; a++) begin
            sx += spot_x[members[c][a]];
            sz += spot_z[members[c][a]];
          end
          rec.mx = 16'(sx / group_size[c]);
          rec.mz = 16'(sz / group_size[c]);
          if (group_size[c] > 1) begin
            bd = span_sq(members[c][1], members[c][0]);
            ir = 1;
            for (int a = 0; a < group_size[c]; a++)
              for (int b = 0; b < group_size[c]; b++) begin
                dd = span_sq(members[c][a], members[c][b]);
                if (dd > bd) begin
                  bd = dd; ir = a; jr = b;
                end
              end
          end
          rec.px = 16'((32'(spot_x[members[c][ir]]) + spot_x[members[c][jr]]) / 2);
          rec.pz = 16'((32'(spot_z[members[c][ir]]) + spot_z[members[c][jr]]) / 2);
        end
        fresh = {fresh, rec};
        tot++;
      end
    end
    if (tot > 0) fresh[tot-1].fin = 1'b1;
  endtask

  task automatic predict_item(logic [1:0] k, logic [5:0] r, logic [5:0] c,
                              logic [15:0] x, logic [15:0] z, logic [DIST_W-1:0] d);
    int n;
    fresh.delete();
    case (k)
      KIND_SPOT: begin
        spot_x[r] = x; spot_z[r] = z;
      end
      KIND_DIST: begin
        if (c < r) begin
          link_dist[r][c] = d;
        end
      end
      KIND_START: begin
        n = count_reg == 0 ? 1 : (count_reg > NSPOT ? NSPOT : count_reg);
        cluster_and_list(n);
        starts++;
      end
      default: ;
    endcase
  endtask

  // offer one item and wait for its transfer
  task automatic send_item(logic [1:0] k, logic [5:0] r, logic [5:0] c, logic [15:0] x,
                           logic [15:0] z, logic [DIST_W-1:0] d, bit typed = 0,
                           member_rec_t want = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; row_index <= r; col_index <= c;
    pos_x <= x; pos_z <= z; distance <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(k, r, c, x, z, d);
    if (typed) pending_members = {pending_members, want};
    else pending_members = {pending_members, fresh};
    if (!(k == KIND_UNUSED || (k == KIND_DIST && c >= r))) accepted_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_members.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [DIST_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_LINK) merge_limit = val;
    else count_reg = val[6:0];
  endtask

  task automatic send_noise();
    logic [5:0] r;
    r = 6'($urandom);
    if ($urandom_range(1))
      send_item(KIND_UNUSED, r, 6'($urandom), 16'($urandom), 16'($urandom),
                DIST_W'($urandom));
    else
      send_item(KIND_DIST, r, 6'($urandom_range(r, 63)), 16'($urandom), 16'($urandom),
                DIST_W'($urandom));
  endtask

  function automatic logic [DIST_W-1:0] rand_link();
    return ($urandom_range(15) == 0) ? DIST_FULL & DIST_W'($urandom)
                                     : DIST_W'($urandom_range(0, 255));
  endfunction

  // load a full matrix of n spots, then start, perhaps again with a new limit
  task automatic cluster_job(int n, logic [6:0] count_raw);
    write_reg(CFG_SPOT_COUNT, DIST_W'(count_raw));
    case ($urandom_range(3))
      0: write_reg(CFG_MAX_LINK, '0);
      1: write_reg(CFG_MAX_LINK, DIST_FULL);
      default: write_reg(CFG_MAX_LINK, DIST_W'($urandom_range(0, 300)));
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_noise();
      send_item(KIND_SPOT, 6'(i), 6'($urandom), 16'($urandom), 16'($urandom),
                DIST_W'($urandom));
    end
    for (int i = 1; i < n; i++)
      for (int j = 0; j < i; j++) begin
        if ($urandom_range(19) == 0) send_noise();
        send_item(KIND_DIST, 6'(i), 6'(j), 16'($urandom), 16'($urandom), rand_link());
      end
    send_item(KIND_START, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
              DIST_W'($urandom));
    if ($urandom_range(2) == 0) begin
      // repeated start on the matrix the last run left behind
      write_reg(CFG_MAX_LINK, DIST_W'($urandom_range(0, 600)));
      send_item(KIND_START, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                DIST_W'($urandom));
    end
  endtask

  // receiver side: random stalls, in-order comparison
  always @(posedge clk) begin
    member_rec_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{cluster_id, spot_index, mean_x, mean_z, mid_x, mid_z, cluster_end, last_o};
        members_seen++;
        if (pending_members.size() == 0) begin
          errors++;
          $display("%0t unexpected result: got %p", $time, got);
        end else begin
          want = pending_members.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t mismatch: expected %p actual %p", $time, want, got);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  stim_row_t directed [$];

  function automatic stim_row_t item_row(logic [1:0] k, logic [5:0] r, logic [5:0] c,
                                         logic [15:0] x, logic [15:0] z,
                                         logic [DIST_W-1:0] d);
    stim_row_t s;
    s = '{default: '0};
    s.k = k; s.r = r; s.c = c; s.x = x; s.z = z; s.d = d;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [0:0] i, logic [DIST_W-1:0] v);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1; s.ci = i; s.cv = v;
    return s;
  endfunction

  function automatic stim_row_t single_start(logic [15:0] x, logic [15:0] z);
    stim_row_t s;
    s = item_row(KIND_START, 0, 0, 0, 0, 0);
    s.typed = 1;
    s.want = '{6'd0, 6'd0, x, z, x, z, 1'b1, 1'b1};
    return s;
  endfunction

  function automatic void add_row(stim_row_t s);
    directed = {directed, s};
  endfunction

  initial begin
    // one lone spot at the corners of the map, then a four-spot matrix
    add_row(item_row(KIND_SPOT, 0, 0, 16'hFFFF, 16'h0000, 0));
    add_row(single_start(16'hFFFF, 16'h0000));
    add_row(item_row(KIND_SPOT, 0, 63, 16'h0000, 16'hFFFF, DIST_FULL));
    add_row(item_row(KIND_UNUSED, 63, 63, 16'hFFFF, 16'hFFFF, DIST_FULL));
    add_row(single_start(16'h0000, 16'hFFFF));
    add_row(cfg_row(CFG_SPOT_COUNT, 0));
    add_row(single_start(16'h0000, 16'hFFFF));
    add_row(cfg_row(CFG_SPOT_COUNT, 4));
    add_row(cfg_row(CFG_MAX_LINK, 0));
    add_row(item_row(KIND_SPOT, 1, 0, 16'hFFFF, 16'hFFFF, 0));
    add_row(item_row(KIND_SPOT, 2, 0, 16'h1234, 16'h8000, 0));
    add_row(item_row(KIND_SPOT, 3, 0, 16'h0001, 16'h7FFF, 0));
    add_row(item_row(KIND_DIST, 1, 0, 0, 0, 0));
    add_row(item_row(KIND_DIST, 2, 0, 0, 0, DIST_FULL));
    add_row(item_row(KIND_DIST, 2, 1, 0, 0, 5));
    add_row(item_row(KIND_DIST, 3, 0, 0, 0, 5));
    add_row(item_row(KIND_DIST, 3, 1, 0, 0, DIST_FULL));
    add_row(item_row(KIND_DIST, 3, 2, 0, 0, 7));
    add_row(item_row(KIND_DIST, 2, 2, 0, 0, 1));      // on the diagonal
    add_row(item_row(KIND_DIST, 1, 63, 0, 0, 1));     // above the diagonal
    add_row(item_row(KIND_START, 0, 0, 0, 0, 0));
    add_row(cfg_row(CFG_MAX_LINK, DIST_FULL));
    add_row(item_row(KIND_START, 0, 0, 0, 0, 0));

    merge_limit = '0;
    count_reg = 7'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].ci, directed[i].cv);
      else send_item(directed[i].k, directed[i].r, directed[i].c, directed[i].x,
                     directed[i].z, directed[i].d, directed[i].typed, directed[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 32 : (phase == 1 ? 80 : 0);
      recv_stall_pct = phase == 0 ? 80 : (phase == 1 ? 32 : 0);
      while (accepted_items < 33 * (phase + 1) + 10) begin
        int n;
        n = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 6);
        cluster_job(n, 7'(n));
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d load/start transfers, %0d starts, %0d member results",
             accepted_items, starts, members_seen);
    if (errors == 0 && pending_members.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_members.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
